>>> rtl/rgb_triple_text_parser_defines.svh
// ----------------------------------------------------------------------------
// RGB triple text parser assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RGB_TRIPLE_TEXT_PARSER_DEFINES_SVH
`define RGB_TRIPLE_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RTP_ASSERT_IMP(label, ante, cons, msg)
`define RTP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/rgbp_pkg.sv
// ----------------------------------------------------------------------------
// RGB triple text parser package
// Shared types and constants for the front, queue and back of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbp_pkg;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_COMMA,
    CLS_OTHER,
    CLS_END
  } char_class_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Position within the current field.
  typedef enum logic [1:0] {
    PHASE_LEAD,
    PHASE_BODY,
    PHASE_TRAIL
  } phase_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_STRUCT = 2'd1;
  localparam logic [1:0] STATUS_VALUE  = 2'd2;

  // Queue geometry; the depth is a power of two so the pointers wrap freely.
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field value limits and the fixed alpha byte.
  localparam logic [8:0] VALUE_MAX = 9'd255;
  localparam logic [8:0] VALUE_SAT = 9'd256;
  localparam logic [7:0] ALPHA     = 8'hFF;

  // Output stream width: status then colour, padded to whole bytes.
  localparam int OUT_W = 40;

endpackage

`default_nettype wire

>>> rtl/rgbp_front.sv
// ----------------------------------------------------------------------------
// RGB triple text parser front end
// Accepts input items, classifies each character and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // ch[7:0]
  input  wire logic               s_tlast,   // is_end
  input  wire rgbp_pkg::fifo_stat_t fifo_stat,
  output logic                    push,
  output rgbp_pkg::item_t         item
);

  logic            held;
  rgbp_pkg::item_t cls_item;

  // Classify the incoming character; an end item overrides the character.
  // The digits '0' to '9' carry their value in the low nibble.
  always_comb begin
    cls_item.digit = s_tdata[3:0];
    priority if (s_tlast) begin
      cls_item.cls = rgbp_pkg::CLS_END;
    end else if (s_tdata == rgbp_pkg::CH_COMMA) begin
      cls_item.cls = rgbp_pkg::CLS_COMMA;
    end else if (s_tdata == rgbp_pkg::CH_SPACE) begin
      cls_item.cls = rgbp_pkg::CLS_SPACE;
    end else if (s_tdata >= rgbp_pkg::CH_ZERO && s_tdata <= rgbp_pkg::CH_NINE) begin
      cls_item.cls = rgbp_pkg::CLS_DIGIT;
    end else begin
      cls_item.cls = rgbp_pkg::CLS_OTHER;
    end
  end

  // The holding register drains into the queue whenever there is room.
  assign push     = held && !fifo_stat.full;
  assign s_tready = !held || !fifo_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= cls_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rgbp_fifo.sv
// ----------------------------------------------------------------------------
// RGB triple text parser queue
// Short register queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbp_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire rgbp_pkg::item_t      wr_item,
  input  wire logic                 pop,
  output rgbp_pkg::item_t           rd_item,
  output rgbp_pkg::fifo_stat_t      stat
);

  rgbp_pkg::item_t                 mem [rgbp_pkg::FIFO_DEPTH];
  logic [rgbp_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [rgbp_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [rgbp_pkg::FIFO_CW-1:0]    count;

  assign rd_item    = mem[rd_ptr];
  assign stat.full  = (count == rgbp_pkg::FIFO_CW'(rgbp_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rgbp_back.sv
// ----------------------------------------------------------------------------
// RGB triple text parser back end
// Applies each classified item to the field state and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rgbp_pkg::item_t             item,
  input  wire rgbp_pkg::fifo_stat_t        fifo_stat,
  output logic                             pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [rgbp_pkg::OUT_W-1:0]       m_tdata    // status[1:0], color[33:2]
);

  // Parser state.
  logic [1:0]       field_index;
  logic [1:0]       comma_count;
  logic [8:0]       field_value;
  rgbp_pkg::phase_t field_phase;
  logic             field_raw_nonempty;
  logic             structure_bad;
  logic             value_bad;
  logic             seen_nonspace;
  logic             last_nonspace_comma;
  logic [23:0]      packed_rgb;

  logic [1:0]       field_index_next;
  logic [1:0]       comma_count_next;
  logic [8:0]       field_value_next;
  rgbp_pkg::phase_t field_phase_next;
  logic             field_raw_nonempty_next;
  logic             structure_bad_next;
  logic             value_bad_next;
  logic             seen_nonspace_next;
  logic             last_nonspace_comma_next;
  logic [23:0]      packed_rgb_next;

  // Result register.
  logic [1:0]       out_status;
  logic [31:0]      out_color;
  logic [1:0]       status_next;
  logic [31:0]      color_next;
  logic             load_out;

  // Closing a field, shared by the comma and end cases.
  logic             close_bad;
  logic [23:0]      packed_closed;
  logic [1:0]       index_closed;
  logic [11:0]      prod;
  logic [8:0]       value_sat;
  logic             end_struct_bad;
  logic             end_value_bad;

  assign pop = !fifo_stat.empty
            && (item.cls != rgbp_pkg::CLS_END || !m_tvalid || m_tready);

  always_comb begin
    close_bad     = (field_phase == rgbp_pkg::PHASE_LEAD) || (field_value > rgbp_pkg::VALUE_MAX);
    packed_closed = packed_rgb;
    unique case (field_index)
      2'd0:    packed_closed[23:16] = field_value[7:0];
      2'd1:    packed_closed[15:8]  = field_value[7:0];
      2'd2:    packed_closed[7:0]   = field_value[7:0];
      default: packed_closed        = packed_rgb;
    endcase
    index_closed = (field_index == 2'd3) ? field_index : field_index + 2'd1;
  end

  // Decimal accumulate as shift-and-add, saturating at 256.
  always_comb begin
    prod      = {field_value, 3'b000} + {2'b00, field_value, 1'b0} + {8'd0, item.digit};
    value_sat = (prod > {3'b000, rgbp_pkg::VALUE_SAT}) ? rgbp_pkg::VALUE_SAT : prod[8:0];
  end

  // Final verdict for an end item.
  always_comb begin
    end_struct_bad = structure_bad || (comma_count != 2'd2)
                  || (seen_nonspace && last_nonspace_comma);
    end_value_bad  = value_bad || close_bad;
  end

  // State update for the item at the head of the queue.
  always_comb begin
    field_index_next         = field_index;
    comma_count_next         = comma_count;
    field_value_next         = field_value;
    field_phase_next         = field_phase;
    field_raw_nonempty_next  = field_raw_nonempty;
    structure_bad_next       = structure_bad;
    value_bad_next           = value_bad;
    seen_nonspace_next       = seen_nonspace;
    last_nonspace_comma_next = last_nonspace_comma;
    packed_rgb_next          = packed_rgb;
    load_out                 = 1'b0;
    status_next              = rgbp_pkg::STATUS_OK;
    color_next               = '0;
    if (pop) begin
      unique case (item.cls)
        rgbp_pkg::CLS_END: begin
          load_out = 1'b1;
          if (end_struct_bad) begin
            status_next = rgbp_pkg::STATUS_STRUCT;
          end else if (end_value_bad) begin
            status_next = rgbp_pkg::STATUS_VALUE;
          end else begin
            status_next = rgbp_pkg::STATUS_OK;
            color_next  = {packed_closed, rgbp_pkg::ALPHA};
          end
          field_index_next         = '0;
          comma_count_next         = '0;
          field_value_next         = '0;
          field_phase_next         = rgbp_pkg::PHASE_LEAD;
          field_raw_nonempty_next  = 1'b0;
          structure_bad_next       = 1'b0;
          value_bad_next           = 1'b0;
          seen_nonspace_next       = 1'b0;
          last_nonspace_comma_next = 1'b0;
          packed_rgb_next          = '0;
        end
        rgbp_pkg::CLS_COMMA: begin
          if (!seen_nonspace || !field_raw_nonempty) begin
            structure_bad_next = 1'b1;
          end
          seen_nonspace_next       = 1'b1;
          last_nonspace_comma_next = 1'b1;
          if (comma_count != 2'd3) begin
            comma_count_next = comma_count + 2'd1;
          end
          value_bad_next          = value_bad || close_bad;
          packed_rgb_next         = packed_closed;
          field_index_next        = index_closed;
          field_value_next        = '0;
          field_phase_next        = rgbp_pkg::PHASE_LEAD;
          field_raw_nonempty_next = 1'b0;
        end
        rgbp_pkg::CLS_SPACE: begin
          field_raw_nonempty_next = 1'b1;
          if (field_phase == rgbp_pkg::PHASE_BODY) begin
            field_phase_next = rgbp_pkg::PHASE_TRAIL;
          end
        end
        rgbp_pkg::CLS_DIGIT, rgbp_pkg::CLS_OTHER: begin
          field_raw_nonempty_next  = 1'b1;
          seen_nonspace_next       = 1'b1;
          last_nonspace_comma_next = 1'b0;
          field_phase_next         = rgbp_pkg::PHASE_BODY;
          if (field_phase == rgbp_pkg::PHASE_TRAIL || item.cls == rgbp_pkg::CLS_OTHER) begin
            value_bad_next = 1'b1;
          end
          if (item.cls == rgbp_pkg::CLS_DIGIT) begin
            field_value_next = value_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index         <= '0;
      comma_count         <= '0;
      field_value         <= '0;
      field_phase         <= rgbp_pkg::PHASE_LEAD;
      field_raw_nonempty  <= 1'b0;
      structure_bad       <= 1'b0;
      value_bad           <= 1'b0;
      seen_nonspace       <= 1'b0;
      last_nonspace_comma <= 1'b0;
      packed_rgb          <= '0;
    end else begin
      field_index         <= field_index_next;
      comma_count         <= comma_count_next;
      field_value         <= field_value_next;
      field_phase         <= field_phase_next;
      field_raw_nonempty  <= field_raw_nonempty_next;
      structure_bad       <= structure_bad_next;
      value_bad           <= value_bad_next;
      seen_nonspace       <= seen_nonspace_next;
      last_nonspace_comma <= last_nonspace_comma_next;
      packed_rgb          <= packed_rgb_next;
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status_next;
      out_color  <= color_next;
    end
  end

  assign m_tdata = {(rgbp_pkg::OUT_W - 34)'(0), out_color, out_status};

endmodule

`default_nettype wire

>>> rtl/rgb_triple_text_parser.sv
// ----------------------------------------------------------------------------
// RGB triple text parser
// Parses "r, g, b" colour text one character per item into a packed colour.
// ----------------------------------------------------------------------------
// The block takes one character per input item and sustains one item per
// clock cycle when nothing stalls. Each item passes a classifying register,
// a four-entry queue and the field-state update; an end item then loads its
// result into the output register, which keeps it until it is taken; while
// it waits, characters of the next text keep flowing into the queue, and
// only a second end item waits behind an untaken result.
// Input tdata carries the character and tlast marks the end item, which gives
// the single result for the text and returns the parser to its reset state.
`default_nettype none
`include "rgb_triple_text_parser_defines.svh"

module rgb_triple_text_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // ch[7:0]
  input  wire logic        s_tlast,   // is_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // status[1:0], color[33:2], zero[39:34]
);

  rgbp_pkg::fifo_stat_t fifo_stat;
  rgbp_pkg::item_t      front_item;
  rgbp_pkg::item_t      head_item;
  logic                 push;
  logic                 pop;
  logic                 pop_end;

  // Front end: accept and classify.
  rgbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .item      (front_item)
  );

  // Queue between the two halves.
  rgbp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (head_item),
    .stat    (fifo_stat)
  );

  // Back end: field state and result.
  rgbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (head_item),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  assign pop_end = pop && (head_item.cls == rgbp_pkg::CLS_END);

  // A new result only follows an end item leaving the queue.
  `RTP_ASSERT_IMP(a_result_from_end, $rose(m_tvalid), $past(pop_end), "result without end item")
  // An end item always leaves a result behind.
  `RTP_ASSERT_NXT(a_end_gives_result, pop_end, m_tvalid, "end item gave no result")
  // A failed status carries a zero colour.
  `RTP_ASSERT_IMP(a_bad_status_zero, m_tvalid && (m_tdata[1:0] != rgbp_pkg::STATUS_OK), m_tdata[33:2] == 32'd0, "nonzero colour on failed status")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// RGB triple text parser testbench
// Sends colour texts one character per item, each closed by an end item, and
// checks every status and colour word against a predictor of the parser or a hand-written result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_CHARS = 1500;
  localparam int HOLDOFF_AT   = 300;
  localparam int HOLDOFF_LEN  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  // One predicted result of an end item.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] colour;
  } colour_word_t;

  // One character or end item, with an optional hand-written result.
  typedef struct {
    logic [7:0]  ch;
    logic        fin;
    bit          hold;
    bit          typed;
    logic [1:0]  status;
    logic [31:0] colour;
  } text_item_t;

  // One directed text: characters right-aligned, last character lowest.
  typedef struct {
    logic [63:0] txt;
    int          len;
    bit          typed;
    logic [1:0]  status;
    logic [31:0] colour;
  } text_case_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  text_item_t   stim[$];
  colour_word_t expected_colours[$];
  int           chars_in;
  int           results_out;
  int           texts_sent;
  int           errors;
  int           idle_cycles;
  int           n_ok;
  int           n_struct;
  int           n_value;

  // Parser state mirrored by the predictor.
  int               fld_idx;
  int               comma_cnt;
  int               fld_val;
  rgbp_pkg::phase_t fld_phase;
  bit               fld_raw;
  bit               struct_bad;
  bit               value_bad;
  bit               seen_ns;
  bit               last_comma;
  logic [23:0]      rgb_acc;

  // Directed texts: extremes, empty text, stray commas, odd characters.
  text_case_t dir_rows [6] = '{
    '{{"255,0,9"}, 7, 1'b1, rgbp_pkg::STATUS_OK, 32'hFF0009FF},
    '{64'h0, 0, 1'b1, rgbp_pkg::STATUS_STRUCT, 32'h0},
    '{{",,"}, 2, 1'b1, rgbp_pkg::STATUS_STRUCT, 32'h0},
    '{{"1 2,", 8'h09, ",", 8'h00, 8'hFF}, 8, 1'b0, rgbp_pkg::STATUS_OK, 32'h0},
    '{{"256,1,1 "}, 8, 1'b1, rgbp_pkg::STATUS_VALUE, 32'h0},
    '{{"1,2,3,4"}, 7, 1'b1, rgbp_pkg::STATUS_STRUCT, 32'h0}
  };

  rgb_triple_text_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Return the predictor to its state after reset.
  task clear_parser();
    fld_idx    = 0;
    comma_cnt  = 0;
    fld_val    = 0;
    fld_phase  = rgbp_pkg::PHASE_LEAD;
    fld_raw    = 1'b0;
    struct_bad = 1'b0;
    value_bad  = 1'b0;
    seen_ns    = 1'b0;
    last_comma = 1'b0;
    rgb_acc    = '0;
  endtask

  // Finish the current field: judge it and store it if it is one of the three.
  task close_field();
    if (fld_phase == rgbp_pkg::PHASE_LEAD || fld_val > rgbp_pkg::VALUE_MAX) value_bad = 1'b1;
    if (fld_idx < 3) begin
      rgb_acc[(2 - fld_idx) * 8 +: 8] = fld_val[7:0];
      fld_idx++;
    end
    fld_val   = 0;
    fld_phase = rgbp_pkg::PHASE_LEAD;
    fld_raw   = 1'b0;
  endtask

  // Advance the parser by one item; an end item yields the colour word.
  task parse_char(input logic [7:0] c, input logic fin, output bit produced,
                  output colour_word_t res);
    produced   = 1'b0;
    res.status = rgbp_pkg::STATUS_OK;
    res.colour = '0;
    if (fin) begin
      close_field();
      if (comma_cnt != 2 || (seen_ns && last_comma)) struct_bad = 1'b1;
      if (struct_bad) res.status = rgbp_pkg::STATUS_STRUCT;
      else if (value_bad) res.status = rgbp_pkg::STATUS_VALUE;
      else res.status = rgbp_pkg::STATUS_OK;
      res.colour = (res.status == rgbp_pkg::STATUS_OK) ? {rgb_acc, rgbp_pkg::ALPHA} : 32'h0;
      produced = 1'b1;
      clear_parser();
    end else if (c == rgbp_pkg::CH_COMMA) begin
      if (!seen_ns || !fld_raw) struct_bad = 1'b1;
      seen_ns    = 1'b1;
      last_comma = 1'b1;
      if (comma_cnt < 3) comma_cnt++;
      close_field();
    end else begin
      fld_raw = 1'b1;
      if (c == rgbp_pkg::CH_SPACE) begin
        if (fld_phase == rgbp_pkg::PHASE_BODY) fld_phase = rgbp_pkg::PHASE_TRAIL;
      end else begin
        seen_ns    = 1'b1;
        last_comma = 1'b0;
        if (fld_phase == rgbp_pkg::PHASE_TRAIL) value_bad = 1'b1;
        fld_phase = rgbp_pkg::PHASE_BODY;
        if (c >= rgbp_pkg::CH_ZERO && c <= rgbp_pkg::CH_NINE) begin
          fld_val = fld_val * 10 + int'(c - rgbp_pkg::CH_ZERO);
          if (fld_val > rgbp_pkg::VALUE_SAT) fld_val = rgbp_pkg::VALUE_SAT;
        end else begin
          value_bad = 1'b1;
        end
      end
    end
  endtask

  task push_char(input logic [7:0] c);
    text_item_t it;
    it = '{c, 1'b0, 1'b0, 1'b0, rgbp_pkg::STATUS_OK, 32'h0};
    stim.push_back(it);
  endtask

  // The character of an end item is ignored, so it is random.
  task push_end(input bit hold, input bit typed, input logic [1:0] st,
                input logic [31:0] col);
    text_item_t it;
    it = '{8'($urandom_range(0, 255)), 1'b1, hold, typed, st, col};
    stim.push_back(it);
  endtask

  // A random text: mostly three well-formed fields, some of them damaged,
  // and the rest plain noise from digits, spaces, commas and any byte.
  task automatic add_random_text(input bit hold);
    logic [7:0] t[$];
    string      s;
    int         kind;
    int         v;
    int         pos;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      for (int f = 0; f < 3; f++) begin
        if (f > 0) t.push_back(rgbp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 2)) t.push_back(rgbp_pkg::CH_SPACE);
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        s = ($urandom_range(0, 7) == 0) ? $sformatf("%03d", v) : $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++) t.push_back(s[k]);
        repeat ($urandom_range(0, 2)) t.push_back(rgbp_pkg::CH_SPACE);
      end
      if (kind >= 55) begin
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, t.size() - 1);
          case ($urandom_range(0, 4))
            0: t[pos] = 8'($urandom_range(0, 255));
            1: t[pos] = rgbp_pkg::CH_COMMA;
            2: t.insert(pos, rgbp_pkg::CH_SPACE);
            3: if (t.size() > 1) t.delete(pos);
            default: t.insert(pos, 8'($urandom_range(0, 255)));
          endcase
        end
      end
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 3))
          0: c = rgbp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          1: c = rgbp_pkg::CH_SPACE;
          2: c = rgbp_pkg::CH_COMMA;
          default: c = 8'($urandom_range(0, 255));
        endcase
        t.push_back(c);
      end
    end
    foreach (t[k]) push_char(t[k]);
    push_end(hold, 1'b0, rgbp_pkg::STATUS_OK, 32'h0);
  endtask

  // Input side: every accepted item goes through the predictor.
  always @(posedge clk) begin : input_monitor
    bit           produced;
    colour_word_t res;
    if (!rst && s_tvalid && s_tready) begin
      parse_char(s_tdata, s_tlast, produced, res);
      if (produced) begin
        if (stim[chars_in].typed) begin
          res.status = stim[chars_in].status;
          res.colour = stim[chars_in].colour;
        end
        expected_colours.push_back(res);
      end
      chars_in++;
    end
  end

  // Output side: compare each result with the oldest expectation.
  always @(posedge clk) begin : output_monitor
    colour_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_out++;
      if (expected_colours.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with none expected", $time, m_tdata);
      end else begin
        want = expected_colours.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          errors++;
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   m_tdata[1:0]);
        end
        if (m_tdata[33:2] !== want.colour) begin
          errors++;
          $display("%0t: colour expected %h, actual %h", $time, want.colour,
                   m_tdata[33:2]);
        end
        case (want.status)
          rgbp_pkg::STATUS_OK:     n_ok++;
          rgbp_pkg::STATUS_STRUCT: n_struct++;
          default:                 n_value++;
        endcase
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall patterns that change now and then, and one long hold-off
  // while the sender keeps offering characters.
  initial begin : receiver
    int  pattern_left;
    int  stall_pct;
    bit  holdoff_done;
    pattern_left = 0;
    stall_pct    = 0;
    holdoff_done = 1'b0;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (!holdoff_done && chars_in >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        pattern_left--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Reset, stimulus build, sender and final report.
  initial begin : sender
    int idx;
    int burst_left;
    int gap;
    int dir_len;
    chars_in    = 0;
    results_out = 0;
    texts_sent  = 0;
    errors      = 0;
    idle_cycles = 0;
    n_ok        = 0;
    n_struct    = 0;
    n_value     = 0;
    clear_parser();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].len; k++)
        push_char(dir_rows[r].txt[8 * (dir_rows[r].len - 1 - k) +: 8]);
      push_end(1'b0, dir_rows[r].typed, dir_rows[r].status, dir_rows[r].colour);
    end
    dir_len = stim.size();
    add_random_text(1'b1);
    while (stim.size() < dir_len + RANDOM_CHARS) add_random_text($urandom_range(0, 39) == 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = 0;
    for (idx = 0; idx < stim.size(); idx++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ((idx / 300) % 3 != 1) gap = $urandom_range(1, 8);
      end
      burst_left--;
      // Wait for every expected result to drain before a held item; otherwise leave a gap if one was drawn.
      if (stim[idx].hold) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (expected_colours.size() != 0);
        @(posedge clk);
      end else if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= stim[idx].ch;
      s_tlast  <= stim[idx].fin;
      do @(posedge clk); while (!s_tready);
      if (stim[idx].fin) texts_sent++;
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (expected_colours.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items forming %0d texts; %0d results compared.", chars_in,
             texts_sent, results_out);
    $display("Results by status: %0d ok, %0d bad structure, %0d bad value.", n_ok,
             n_struct, n_value);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
